>>> rtl/cpcr_pkg.sv
package cpcr_pkg;

    // field widths that the item format fixes
    localparam int COORD_W_DEF = 24;
    localparam int RAD_W       = 20;
    localparam int MASS_W      = 16;
    localparam int MSUM_W      = MASS_W + 1;
    localparam int SUM_W       = RAD_W + 1;
    localparam int SQ_W        = 2 * SUM_W;
    localparam int RT_W        = SQ_W + 1;
    localparam int PROD_W      = 2 * SUM_W;
    localparam int NUM_W       = PROD_W + MASS_W;
    localparam int DEN_W       = SUM_W + MSUM_W + 1;
    localparam int Q_W         = SUM_W;
    localparam int DIVC_W      = DEN_W + Q_W;
    localparam int SQRT_STEPS  = SUM_W;
    localparam int LANES       = 4;
    localparam int QUEUE_DEPTH = 4;

    // classified request handed from front to back
    typedef struct packed {
        logic              hit;
        logic              skip;
        logic              negx;
        logic              negy;
        logic [SUM_W-1:0]  adx;
        logic [SUM_W-1:0]  ady;
        logic [SUM_W-1:0]  rsum;
        logic [SQ_W-1:0]   d2;
        logic [MASS_W-1:0] ma;
        logic [MASS_W-1:0] mb;
    } t_front_item;

    // control bits that ride along the back pipeline
    typedef struct packed {
        logic hit;
        logic skip;
        logic negx;
        logic negy;
    } t_tail;

endpackage

>>> rtl/circle_pair_collision_resolve.sv
// circle pair overlap test and push-apart resolution
// throughput: one pair per cycle when neither half is stalled;
// 21 square root stages and 21 divider stages, fully pipelined
// the front and back halves stall on their own, parted by a four-entry queue
// reset: synchronous active low, clears all queues and valid bits; no clearing pass
module circle_pair_collision_resolve #(
    parameter int COORD_WIDTH = cpcr_pkg::COORD_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] i_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_y,
    input  logic [cpcr_pkg::RAD_W-1:0]    i_a_radius,
    input  logic [cpcr_pkg::MASS_W-1:0]   i_a_mass,
    input  logic signed [COORD_WIDTH-1:0] i_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_y,
    input  logic [cpcr_pkg::RAD_W-1:0]    i_b_radius,
    input  logic [cpcr_pkg::MASS_W-1:0]   i_b_mass,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_hit,
    output logic signed [COORD_WIDTH-1:0] o_push_a_x,
    output logic signed [COORD_WIDTH-1:0] o_push_a_y,
    output logic signed [COORD_WIDTH-1:0] o_push_b_x,
    output logic signed [COORD_WIDTH-1:0] o_push_b_y
);
    import cpcr_pkg::*;

    localparam int OUT_W = 1 + LANES * COORD_WIDTH;

    t_front_item f_item;
    t_front_item q_item;
    logic        f_valid;
    logic        q_full, q_empty, q_rd;
    logic        b_valid, b_hit, o_q_full;
    logic [LANES-1:0][COORD_WIDTH-1:0] b_push;
    logic [OUT_W-1:0] o_q_rdata;

    // front: differences, squares, classification
    cpcr_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_a_x      (i_a_x),
        .i_a_y      (i_a_y),
        .i_a_radius (i_a_radius),
        .i_a_mass   (i_a_mass),
        .i_b_x      (i_b_x),
        .i_b_y      (i_b_y),
        .i_b_radius (i_b_radius),
        .i_b_mass   (i_b_mass),
        .o_valid    (f_valid),
        .o_item     (f_item),
        .i_q_full   (q_full)
    );

    // queue between front and back
    cpcr_fifo #(.WIDTH($bits(t_front_item)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid && !q_full),
        .i_wdata (f_item),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_item),
        .o_empty (q_empty)
    );

    // back: root, products, division
    cpcr_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .o_pop   (q_rd),
        .i_item  (q_item),
        .o_valid (b_valid),
        .o_hit   (b_hit),
        .o_push  (b_push),
        .i_full  (o_q_full)
    );

    // result queue
    cpcr_fifo #(.WIDTH(OUT_W), .DEPTH(QUEUE_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (b_valid && !o_q_full),
        .i_wdata ({b_hit, b_push[0], b_push[1], b_push[2], b_push[3]}),
        .o_full  (o_q_full),
        .i_rd    (pop && !empty),
        .o_rdata (o_q_rdata),
        .o_empty (empty)
    );

    assign {o_hit, o_push_a_x, o_push_a_y, o_push_b_x, o_push_b_y} = o_q_rdata;
endmodule

>>> rtl/cpcr_fifo.sv
module cpcr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 1'b1;
            if (i_rd) r_rp <= r_rp + 1'b1;
            if (i_wr && !i_rd) r_cnt <= r_cnt + 1'b1;
            else if (!i_wr && i_rd) r_cnt <= r_cnt - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_wdata;
    end
endmodule

>>> rtl/cpcr_front.sv
module cpcr_front #(
    parameter int COORD_WIDTH = cpcr_pkg::COORD_W_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic signed [COORD_WIDTH-1:0]       i_a_x,
    input  logic signed [COORD_WIDTH-1:0]       i_a_y,
    input  logic [cpcr_pkg::RAD_W-1:0]          i_a_radius,
    input  logic [cpcr_pkg::MASS_W-1:0]         i_a_mass,
    input  logic signed [COORD_WIDTH-1:0]       i_b_x,
    input  logic signed [COORD_WIDTH-1:0]       i_b_y,
    input  logic [cpcr_pkg::RAD_W-1:0]          i_b_radius,
    input  logic [cpcr_pkg::MASS_W-1:0]         i_b_mass,
    output logic                                o_valid,
    output cpcr_pkg::t_front_item               o_item,
    input  logic                                i_q_full
);
    import cpcr_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int XW = (DW > SUM_W) ? DW : SUM_W;

    logic en;
    logic r_v1, r_v2, r_v3;

    logic signed [DW-1:0] r1_dx, r1_dy;
    logic [SUM_W-1:0]     r1_rsum;
    logic [MASS_W-1:0]    r1_ma, r1_mb;

    logic [DW-1:0]        n_adx_full, n_ady_full;
    logic [XW-1:0]        n_adx_ext, n_ady_ext;
    logic                 n_far;
    logic [SUM_W-1:0]     r2_adx, r2_ady, r2_rsum;
    logic                 r2_far, r2_negx, r2_negy;
    logic [MASS_W-1:0]    r2_ma, r2_mb;

    logic [SQ_W-1:0]      r3_sqx, r3_sqy, r3_rs2;
    logic [SUM_W-1:0]     r3_adx, r3_ady, r3_rsum;
    logic                 r3_far, r3_negx, r3_negy;
    logic [MASS_W-1:0]    r3_ma, r3_mb;

    logic [SQ_W:0]        n_d2;
    logic                 n_hit;

    // the whole front advances unless its last request cannot leave
    assign en      = !(r_v3 && i_q_full);
    assign o_full  = !en;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1: centre differences and radius sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx   <= DW'(i_a_x) - DW'(i_b_x);
            r1_dy   <= DW'(i_a_y) - DW'(i_b_y);
            r1_rsum <= SUM_W'(i_a_radius) + SUM_W'(i_b_radius);
            r1_ma   <= i_a_mass;
            r1_mb   <= i_b_mass;
        end
    end

    // stage 2: magnitudes and far-apart rejection
    assign n_adx_full = r1_dx[DW-1] ? DW'(-r1_dx) : DW'(r1_dx);
    assign n_ady_full = r1_dy[DW-1] ? DW'(-r1_dy) : DW'(r1_dy);
    assign n_adx_ext  = XW'(n_adx_full);
    assign n_ady_ext  = XW'(n_ady_full);
    assign n_far      = (n_adx_ext >= XW'(r1_rsum)) || (n_ady_ext >= XW'(r1_rsum));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_adx  <= n_adx_ext[SUM_W-1:0];
            r2_ady  <= n_ady_ext[SUM_W-1:0];
            r2_far  <= n_far;
            r2_negx <= r1_dx[DW-1];
            r2_negy <= r1_dy[DW-1];
            r2_rsum <= r1_rsum;
            r2_ma   <= r1_ma;
            r2_mb   <= r1_mb;
        end
    end

    // stage 3: squares
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sqx  <= r2_adx * r2_adx;
            r3_sqy  <= r2_ady * r2_ady;
            r3_rs2  <= r2_rsum * r2_rsum;
            r3_adx  <= r2_adx;
            r3_ady  <= r2_ady;
            r3_rsum <= r2_rsum;
            r3_far  <= r2_far;
            r3_negx <= r2_negx;
            r3_negy <= r2_negy;
            r3_ma   <= r2_ma;
            r3_mb   <= r2_mb;
        end
    end

    // squared distance, exact hit test and classification
    assign n_d2  = {1'b0, r3_sqx} + {1'b0, r3_sqy};
    assign n_hit = !r3_far && (n_d2 < {1'b0, r3_rs2});

    always_comb begin
        o_item.hit  = n_hit;
        o_item.skip = !n_hit || (n_d2 == '0) || ((r3_ma == '0) && (r3_mb == '0));
        o_item.negx = r3_negx;
        o_item.negy = r3_negy;
        o_item.adx  = r3_adx;
        o_item.ady  = r3_ady;
        o_item.rsum = r3_rsum;
        o_item.d2   = n_d2[SQ_W-1:0];
        o_item.ma   = r3_ma;
        o_item.mb   = r3_mb;
    end
endmodule

>>> rtl/cpcr_back.sv
module cpcr_back #(
    parameter int COORD_WIDTH = cpcr_pkg::COORD_W_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_empty,
    output logic                                         o_pop,
    input  cpcr_pkg::t_front_item                        i_item,
    output logic                                         o_valid,
    output logic                                         o_hit,
    output logic [cpcr_pkg::LANES-1:0][COORD_WIDTH-1:0]  o_push,
    input  logic                                         i_full
);
    import cpcr_pkg::*;

    localparam int EW = COORD_WIDTH + Q_W;

    logic en;

    // square root stages
    logic        r_sq_v    [SQRT_STEPS+1];
    t_front_item r_sq_item [SQRT_STEPS+1];
    logic [RT_W-1:0] r_sq_rem  [SQRT_STEPS+1];
    logic [RT_W-1:0] r_sq_root [SQRT_STEPS+1];

    // overlap and products
    logic              r_m1_v, r_m2_v;
    t_front_item       r_m1_item;
    logic [SUM_W-1:0]  r_m1_ovl, r_m1_dist;
    logic [PROD_W-1:0] r_m2_tx, r_m2_ty;
    logic [DEN_W-1:0]  r_m2_den;
    logic [MASS_W-1:0] r_m2_ma, r_m2_mb;
    t_tail             r_m2_ctl;
    logic [DEN_W-2:0]  n_dm;

    // divider stages, stage zero holds numerators
    logic             r_dv_v   [Q_W+1];
    t_tail            r_dv_ctl [Q_W+1];
    logic [DEN_W-1:0] r_dv_den [Q_W+1];
    logic [NUM_W-1:0] r_dv_rem [Q_W+1][LANES];
    logic [Q_W-1:0]   r_dv_q   [Q_W+1][LANES];

    // global advance: only a finished result that cannot leave holds the pipe
    assign en    = !(r_dv_v[Q_W] && i_full);
    assign o_pop = en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sq_v[0] <= 1'b0;
        else if (en) r_sq_v[0] <= o_pop;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_item[0] <= i_item;
            r_sq_rem[0]  <= RT_W'(i_item.d2);
            r_sq_root[0] <= '0;
        end
    end

    // one root digit per stage
    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
        localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (SQRT_STEPS - 1 - s));
        logic [RT_W-1:0] n_sum;
        logic            n_ge;

        assign n_sum = r_sq_root[s] + BIT;
        assign n_ge  = (r_sq_rem[s] >= n_sum);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_v[s+1] <= 1'b0;
            else if (en) r_sq_v[s+1] <= r_sq_v[s];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_item[s+1] <= r_sq_item[s];
                r_sq_rem[s+1]  <= n_ge ? (r_sq_rem[s] - n_sum) : r_sq_rem[s];
                r_sq_root[s+1] <= n_ge ? ((r_sq_root[s] >> 1) + BIT) : (r_sq_root[s] >> 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v    <= 1'b0;
            r_m2_v    <= 1'b0;
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_m1_v    <= r_sq_v[SQRT_STEPS];
            r_m2_v    <= r_m1_v;
            r_dv_v[0] <= r_m2_v;
        end
    end

    // overlap from the root
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_item <= r_sq_item[SQRT_STEPS];
            r_m1_dist <= r_sq_root[SQRT_STEPS][SUM_W-1:0];
            r_m1_ovl  <= r_sq_item[SQRT_STEPS].rsum - r_sq_root[SQRT_STEPS][SUM_W-1:0];
        end
    end

    // offset times overlap, and twice distance times mass sum
    assign n_dm = r_m1_dist * (MSUM_W'(r_m1_item.ma) + MSUM_W'(r_m1_item.mb));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_tx       <= r_m1_item.adx * r_m1_ovl;
            r_m2_ty       <= r_m1_item.ady * r_m1_ovl;
            r_m2_den      <= {n_dm, 1'b0};
            r_m2_ma       <= r_m1_item.ma;
            r_m2_mb       <= r_m1_item.mb;
            r_m2_ctl.hit  <= r_m1_item.hit;
            r_m2_ctl.skip <= r_m1_item.skip;
            r_m2_ctl.negx <= r_m1_item.negx;
            r_m2_ctl.negy <= r_m1_item.negy;
        end
    end

    // numerators times the other mass
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_rem[0][0] <= r_m2_tx * r_m2_mb;
            r_dv_rem[0][1] <= r_m2_ty * r_m2_mb;
            r_dv_rem[0][2] <= r_m2_tx * r_m2_ma;
            r_dv_rem[0][3] <= r_m2_ty * r_m2_ma;
            for (int k = 0; k < LANES; k++) r_dv_q[0][k] <= '0;
            r_dv_den[0]    <= r_m2_den;
            r_dv_ctl[0]    <= r_m2_ctl;
        end
    end

    // restoring division, one quotient bit per stage in four lanes
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        localparam int SH = Q_W - 1 - j;
        logic [DIVC_W-1:0] n_dsh;

        assign n_dsh = DIVC_W'(r_dv_den[j]) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_v[j+1] <= 1'b0;
            else if (en) r_dv_v[j+1] <= r_dv_v[j];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_den[j+1] <= r_dv_den[j];
                r_dv_ctl[j+1] <= r_dv_ctl[j];
            end
        end

        for (genvar k = 0; k < LANES; k++) begin : g_lane
            logic [DIVC_W-1:0] n_rem_ext;
            logic [DIVC_W-1:0] n_diff;
            logic              n_ge;

            assign n_rem_ext = DIVC_W'(r_dv_rem[j][k]);
            assign n_ge      = (n_rem_ext >= n_dsh);
            assign n_diff    = n_rem_ext - n_dsh;

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_rem[j+1][k] <= n_ge ? n_diff[NUM_W-1:0] : r_dv_rem[j][k];
                    r_dv_q[j+1][k]   <= r_dv_q[j][k] | (Q_W'(n_ge) << SH);
                end
            end
        end
    end

    // sign and mask the quotients
    assign o_valid = r_dv_v[Q_W];
    assign o_hit   = r_dv_ctl[Q_W].hit;

    for (genvar k = 0; k < LANES; k++) begin : g_enc
        logic          n_neg;
        logic [EW-1:0] n_mag;
        logic [EW-1:0] n_val;

        assign n_neg = (k == 0) ? r_dv_ctl[Q_W].negx :
                       (k == 1) ? r_dv_ctl[Q_W].negy :
                       (k == 2) ? !r_dv_ctl[Q_W].negx : !r_dv_ctl[Q_W].negy;
        assign n_mag = r_dv_ctl[Q_W].skip ? '0 : EW'(r_dv_q[Q_W][k]);
        assign n_val = n_neg ? (EW'(0) - n_mag) : n_mag;
        assign o_push[k] = n_val[COORD_WIDTH-1:0];
    end
endmodule
